// ===== sv/gdn_pkg.sv =====
// shared types, constants and calendar helpers for the day number unit
`default_nettype none
package gdn_pkg;

  localparam int unsigned DN_W = 25;

  localparam int unsigned DAYS_400   = 146097;
  localparam int unsigned DAYS_100   = 36524;
  localparam int unsigned DAYS_4     = 1461;
  localparam int unsigned DAYS_1     = 365;
  localparam int unsigned RECIP_100  = 5243;
  localparam int unsigned RECIP_400C = 29398;
  localparam int unsigned RECIP_4C   = 717;

  typedef enum logic [2:0] {
    OP_LEAP  = 3'd0,
    OP_ORD   = 3'd1,
    OP_DNUM  = 3'd2,
    OP_MINUS = 3'd3,
    OP_PLUS  = 3'd4,
    OP_DIST  = 3'd5,
    OP_CMP   = 3'd6,
    OP_BAD   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ORD_EQ = 2'd0,
    ORD_A  = 2'd1,
    ORD_B  = 2'd2
  } order_t;

  typedef struct packed {
    op_t         op;
    status_t     status;
    logic        is_leap;
    logic [8:0]  day_of_year;
    logic [21:0] day_number;
    logic [21:0] distance;
    order_t      order;
  } carry_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      4'd2: month_len = leap ? 5'd29 : 5'd28;
      default: month_len = 5'd31;
    endcase
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] s;
    case (m)
      4'd2: s = 9'd31;
      4'd3: s = 9'd59;
      4'd4: s = 9'd90;
      4'd5: s = 9'd120;
      4'd6: s = 9'd151;
      4'd7: s = 9'd181;
      4'd8: s = 9'd212;
      4'd9: s = 9'd243;
      4'd10: s = 9'd273;
      4'd11: s = 9'd304;
      4'd12: s = 9'd334;
      default: s = 9'd0;
    endcase
    month_start = (leap && m >= 4'd3) ? s + 9'd1 : s;
  endfunction

endpackage
`default_nettype wire

// ===== sv/gregorian_day_number_unit.sv =====
// gregorian_day_number_unit: pipelined calendar conversion, compare and shift unit
//
//  channel  | handshake      | fields
//  ---------+----------------+-----------------------------------------------------
//  command  | start / busy   | opcode day_a month_a year_a day_b month_b year_b offset_days
//  result   | done           | is_leap day_of_year day_number out_day out_month out_year
//           |                | distance order status
//
// twelve register stages, one transaction per cycle
// the depth is set by the day number to date conversion (two reciprocal multiply,
// product subtract and correction rounds)
// busy stays low; synchronous reset empties the pipeline
`default_nettype none
module gregorian_day_number_unit import gdn_pkg::*; #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [2:0]  opcode,
  input  wire  [4:0]  day_a,
  input  wire  [3:0]  month_a,
  input  wire  [13:0] year_a,
  input  wire  [4:0]  day_b,
  input  wire  [3:0]  month_b,
  input  wire  [13:0] year_b,
  input  wire  [21:0] offset_days,
  output logic        done,
  output logic        is_leap,
  output logic [8:0]  day_of_year,
  output logic [21:0] day_number,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [13:0] out_year,
  output logic [21:0] distance,
  output logic [1:0]  order,
  output logic [1:0]  status
);

  localparam int unsigned LAST_DN =
    MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400 - 1;

  assign busy = 1'b0;

  logic [10:0] v;

  // stage 1
  logic [2:0]  op1;
  logic [4:0]  d1 [2];
  logic [3:0]  m1 [2];
  logic [13:0] y1 [2];
  logic [21:0] k1;
  logic [22:0] p365_1 [2];
  logic [11:0] q4_1 [2];
  logic [26:0] pq100_1 [2];
  logic [24:0] pq400_1 [2];
  logic [26:0] yq100_1 [2];

  // stage 2
  logic [2:0]  op2;
  logic [21:0] k2;
  status_t     st2;
  logic        leap2;
  logic [8:0]  ord2 [2];
  logic [22:0] p365_2 [2];
  logic [11:0] q4_2 [2];
  logic [7:0]  q100_2 [2];
  logic [5:0]  q400_2 [2];

  // stage 3
  logic [2:0]    op3;
  logic [21:0]   k3;
  status_t       st3;
  logic          leap3;
  logic [8:0]    ord3;
  logic [DN_W-1:0] n3 [2];

  // stage 4 onward
  carry_t          cy [8];
  logic [DN_W-1:0] t4;

  logic [39:0]     prod5;
  logic [DN_W-1:0] t5;
  logic [7:0]      q6;
  logic [18:0]     r6;
  logic [7:0]      q7;
  logic [1:0]      c100_7;
  logic [15:0]     r7;
  logic [7:0]      q8;
  logic [1:0]      c100_8;
  logic [15:0]     r8;
  logic [25:0]     prod8;
  logic [7:0]      q9;
  logic [1:0]      c100_9;
  logic [4:0]      c4_9;
  logic [11:0]     r9;
  logic [7:0]      q10;
  logic [1:0]      c100_10;
  logic [4:0]      c4_10;
  logic [10:0]     r10;
  logic [16:0]     y11;
  logic            leap11;
  logic [8:0]      r11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[9:0], start & ~busy};
    end
  end

  // stage 1: products for day number and leap test
  logic [4:0]  din [2];
  logic [3:0]  min [2];
  logic [13:0] yin [2];
  assign din[0] = day_a;
  assign din[1] = day_b;
  assign min[0] = month_a;
  assign min[1] = month_b;
  assign yin[0] = year_a;
  assign yin[1] = year_b;

  always_ff @(posedge clk) begin
    op1 <= opcode;
    k1  <= offset_days;
    for (int i = 0; i < 2; i++) begin
      d1[i]      <= din[i];
      m1[i]      <= min[i];
      y1[i]      <= yin[i];
      p365_1[i]  <= 23'(yin[i] - 14'd1) * 23'(DAYS_1);
      q4_1[i]    <= 12'((yin[i] - 14'd1) >> 2);
      pq100_1[i] <= 27'(yin[i] - 14'd1) * 27'(RECIP_100);
      pq400_1[i] <= 25'((yin[i] - 14'd1) >> 2) * 25'(RECIP_100);
      yq100_1[i] <= 27'(yin[i]) * 27'(RECIP_100);
    end
  end

  // stage 2: leap, validity, ordinal
  logic [1:0] leap_c, ok_c;
  logic [8:0] ord_c [2];
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      logic [7:0] cq;
      logic       is100;
      cq        = yq100_1[i][26:19];
      is100     = ({1'b0, y1[i]} == 15'(cq * 15'd100));
      leap_c[i] = (y1[i][1:0] == 2'd0) && (!is100 || cq[1:0] == 2'd0);
      ok_c[i]   = (m1[i] >= 4'd1) && (m1[i] <= 4'd12) && (y1[i] != 14'd0) &&
                  ({2'b0, y1[i]} <= 16'(MAX_YEAR)) && (d1[i] != 5'd0) &&
                  (d1[i] <= month_len(m1[i], leap_c[i]));
      ord_c[i]  = month_start(m1[i], leap_c[i]) + 9'(d1[i]);
    end
  end

  always_ff @(posedge clk) begin
    op2   <= op1;
    k2    <= k1;
    leap2 <= leap_c[0];
    if (op1 == OP_BAD || !ok_c[0] || ((op1 == OP_DIST || op1 == OP_CMP) && !ok_c[1])) begin
      st2 <= ST_BAD;
    end else begin
      st2 <= ST_OK;
    end
    for (int i = 0; i < 2; i++) begin
      ord2[i]   <= ord_c[i];
      p365_2[i] <= p365_1[i];
      q4_2[i]   <= q4_1[i];
      q100_2[i] <= pq100_1[i][26:19];
      q400_2[i] <= pq400_1[i][24:19];
    end
  end

  // stage 3: day numbers
  always_ff @(posedge clk) begin
    op3   <= op2;
    k3    <= k2;
    st3   <= st2;
    leap3 <= leap2;
    ord3  <= ord2[0];
    for (int i = 0; i < 2; i++) begin
      n3[i] <= DN_W'(p365_2[i]) + DN_W'(q4_2[i]) - DN_W'(q100_2[i]) +
               DN_W'(q400_2[i]) + DN_W'(ord2[i]) - DN_W'(1);
    end
  end

  // stage 4: shift, distance, order, result selection
  logic [DN_W:0]   sum4;
  logic [DN_W-1:0] dif4;
  logic            oor4;
  carry_t          c4n;
  always_comb begin
    sum4 = {1'b0, n3[0]} + (DN_W + 1)'(k3);
    dif4 = n3[0] - DN_W'(k3);
    oor4 = (op3 == OP_MINUS) ? (DN_W'(k3) > n3[0]) : (sum4 > (DN_W + 1)'(LAST_DN));
    c4n  = '0;
    c4n.op = op_t'(op3);
    if (st3 != ST_OK) begin
      c4n.status = st3;
    end else if ((op3 == OP_MINUS || op3 == OP_PLUS) && oor4) begin
      c4n.status = ST_RANGE;
    end else begin
      c4n.status = ST_OK;
      case (op_t'(op3))
        OP_LEAP: c4n.is_leap = leap3;
        OP_ORD:  c4n.day_of_year = ord3;
        OP_DNUM: c4n.day_number = n3[0][21:0];
        OP_DIST: begin
          if (n3[0] >= n3[1]) begin
            c4n.distance = 22'(n3[0] - n3[1]);
          end else begin
            c4n.distance = 22'(n3[1] - n3[0]);
          end
        end
        OP_CMP: begin
          if (n3[0] < n3[1]) begin
            c4n.order = ORD_A;
          end else if (n3[0] > n3[1]) begin
            c4n.order = ORD_B;
          end else begin
            c4n.order = ORD_EQ;
          end
        end
        default: c4n.is_leap = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cy[0] <= c4n;
    t4    <= (op3 == OP_MINUS) ? dif4 : sum4[DN_W-1:0];
    for (int i = 1; i < 8; i++) begin
      cy[i] <= cy[i-1];
    end
  end

  // stages 5 to 11: day number back to year and day of year
  logic [25:0] r6c;
  logic        corr7;
  logic [17:0] rc7;
  logic [1:0]  c100c;
  logic [15:0] r9c;
  logic [1:0]  c1c;
  always_comb begin
    r6c   = 26'(t5) - 26'(prod5[39:32]) * 26'(DAYS_400);
    corr7 = (r6 >= 19'(DAYS_400));
    rc7   = corr7 ? 18'(r6 - 19'(DAYS_400)) : r6[17:0];
    if (rc7 >= 18'(3 * DAYS_100)) begin
      c100c = 2'd3;
    end else if (rc7 >= 18'(2 * DAYS_100)) begin
      c100c = 2'd2;
    end else if (rc7 >= 18'(DAYS_100)) begin
      c100c = 2'd1;
    end else begin
      c100c = 2'd0;
    end
    r9c = r8 - 16'(prod8[24:20]) * 16'(DAYS_4);
    if (r10 >= 11'(3 * DAYS_1)) begin
      c1c = 2'd3;
    end else if (r10 >= 11'(2 * DAYS_1)) begin
      c1c = 2'd2;
    end else if (r10 >= 11'(DAYS_1)) begin
      c1c = 2'd1;
    end else begin
      c1c = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    prod5   <= 40'(t4) * 40'(RECIP_400C);
    t5      <= t4;
    q6      <= prod5[39:32];
    r6      <= r6c[18:0];
    q7      <= q6 + 8'(corr7);
    c100_7  <= c100c;
    r7      <= 16'(rc7 - 18'(c100c) * 18'(DAYS_100));
    q8      <= q7;
    c100_8  <= c100_7;
    r8      <= r7;
    prod8   <= 26'(r7) * 26'(RECIP_4C);
    q9      <= q8;
    c100_9  <= c100_8;
    c4_9    <= prod8[24:20];
    r9      <= r9c[11:0];
    q10     <= q9;
    c100_10 <= c100_9;
    if (r9 >= 12'(DAYS_4)) begin
      c4_10 <= c4_9 + 5'd1;
      r10   <= 11'(r9 - 12'(DAYS_4));
    end else begin
      c4_10 <= c4_9;
      r10   <= r9[10:0];
    end
    y11    <= 17'(q10) * 17'd400 + 17'(c100_10) * 17'd100 + 17'(c4_10) * 17'd4 +
              17'(c1c) + 17'd1;
    leap11 <= (c1c == 2'd3) && (c4_10 != 5'd24 || c100_10 == 2'd3);
    r11    <= 9'(r10 - 11'(c1c) * 11'(DAYS_1));
  end

  // stage 12: month and day, output registers
  logic [3:0] mon12;
  logic [8:0] dd12;
  always_comb begin
    mon12 = 4'd1;
    for (int mm = 2; mm <= 12; mm++) begin
      if (r11 >= month_start(4'(mm), leap11)) begin
        mon12 = 4'(mm);
      end
    end
    dd12 = r11 - month_start(mon12, leap11) + 9'd1;
  end

  logic shift_ok;
  assign shift_ok = (cy[7].status == ST_OK) && (cy[7].op == OP_MINUS || cy[7].op == OP_PLUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v[10];
    end
    is_leap     <= cy[7].is_leap;
    day_of_year <= cy[7].day_of_year;
    day_number  <= cy[7].day_number;
    distance    <= cy[7].distance;
    order       <= cy[7].order;
    status      <= cy[7].status;
    out_day     <= shift_ok ? dd12[4:0] : 5'd0;
    out_month   <= shift_ok ? mon12 : 4'd0;
    out_year    <= shift_ok ? y11[13:0] : 14'd0;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst) start |-> ##12 done)
    else $error("transaction lost in pipeline");
  a_no_ghost: assert property (@(posedge clk) disable iff (rst) done |-> $past(start, 12))
    else $error("result without transaction");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> out_day == 5'd0 && out_month == 4'd0 && day_number == 22'd0)
    else $error("error result carries data");
  a_date_ok: assert property (@(posedge clk) disable iff (rst)
    done && out_month != 4'd0 |-> out_day != 5'd0 && out_month <= 4'd12 && out_year != 14'd0)
    else $error("shifted date malformed");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_gregorian_day_number_unit.sv =====
// self-checking testbench for the gregorian day number unit
`timescale 1ns / 1ps
module tb_gregorian_day_number_unit;
  import gdn_pkg::*;

  localparam int unsigned YEAR_LIMIT = 9999;
  localparam int unsigned MAX_DAYNO = 3652058;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    op_t         op;
    logic [4:0]  da;
    logic [3:0]  ma;
    logic [13:0] ya;
    logic [4:0]  db;
    logic [3:0]  mb;
    logic [13:0] yb;
    logic [21:0] k;
  } cmd_t;

  typedef struct packed {
    logic        is_leap;
    logic [8:0]  day_of_year;
    logic [21:0] day_number;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [21:0] distance;
    logic [1:0]  order;
    logic [1:0]  status;
  } answer_t;

  typedef struct {
    cmd_t    c;
    bit      fixed;
    answer_t a;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] opcode = '0;
  logic [4:0] day_a = 5'd1;
  logic [3:0] month_a = 4'd1;
  logic [13:0] year_a = 14'd1;
  logic [4:0] day_b = 5'd1;
  logic [3:0] month_b = 4'd1;
  logic [13:0] year_b = 14'd1;
  logic [21:0] offset_days = '0;
  logic done, is_leap;
  logic [8:0] day_of_year;
  logic [21:0] day_number, distance;
  logic [4:0] out_day;
  logic [3:0] out_month;
  logic [13:0] out_year;
  logic [1:0] order, status;

  answer_t pending_answers[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int cycles = 0;
  int gap_pct = 14;

  always #6 clk = ~clk;

  gregorian_day_number_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .day_a(day_a), .month_a(month_a), .year_a(year_a), .day_b(day_b),
    .month_b(month_b), .year_b(year_b), .offset_days(offset_days), .done(done),
    .is_leap(is_leap), .day_of_year(day_of_year), .day_number(day_number),
    .out_day(out_day), .out_month(out_month), .out_year(out_year),
    .distance(distance), .order(order), .status(status)
  );

  function automatic bit leap_of(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in(int unsigned m, int unsigned y);
    case (m)
      4, 6, 9, 11: return 30;
      2: return leap_of(y) ? 29 : 28;
      default: return 31;
    endcase
  endfunction

  function automatic bit valid_date(int unsigned d, int unsigned m, int unsigned y);
    if (m < 1 || m > 12 || y < 1 || y > YEAR_LIMIT) return 0;
    return d >= 1 && d <= days_in(m, y);
  endfunction

  function automatic int unsigned yday(int unsigned d, int unsigned m, int unsigned y);
    int unsigned s;
    s = d;
    for (int unsigned i = 1; i < m; i++) s += days_in(i, y);
    return s;
  endfunction

  function automatic int unsigned serial_day(int unsigned d, int unsigned m,
                                             int unsigned y);
    int unsigned p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400 + yday(d, m, y) - 1;
  endfunction

  function automatic answer_t calendar_answer(cmd_t c);
    answer_t r;
    int unsigned na, nb, t, r0, q100, q1, y, m;
    r = '0;
    if (c.op == OP_BAD || !valid_date(c.da, c.ma, c.ya) ||
        ((c.op == OP_DIST || c.op == OP_CMP) && !valid_date(c.db, c.mb, c.yb))) begin
      r.status = ST_BAD;
      return r;
    end
    na = serial_day(c.da, c.ma, c.ya);
    nb = serial_day(c.db, c.mb, c.yb);
    case (c.op)
      OP_LEAP: r.is_leap = leap_of(c.ya);
      OP_ORD: r.day_of_year = yday(c.da, c.ma, c.ya);
      OP_DNUM: r.day_number = na;
      OP_MINUS, OP_PLUS: begin
        if (c.op == OP_MINUS && c.k > na) begin
          r.status = ST_RANGE;
          return r;
        end
        t = (c.op == OP_MINUS) ? na - c.k : na + c.k;
        if (t > serial_day(31, 12, YEAR_LIMIT)) begin
          r.status = ST_RANGE;
          return r;
        end
        y = (t / DAYS_400) * 400;
        r0 = t % DAYS_400;
        q100 = r0 / DAYS_100;
        if (q100 > 3) q100 = 3;
        r0 -= q100 * DAYS_100;
        y += q100 * 100 + (r0 / DAYS_4) * 4;
        r0 %= DAYS_4;
        q1 = r0 / DAYS_1;
        if (q1 > 3) q1 = 3;
        r0 -= q1 * DAYS_1;
        y += q1 + 1;
        m = 1;
        while (m < 12 && r0 >= days_in(m, y)) begin
          r0 -= days_in(m, y);
          m++;
        end
        r.out_day = r0 + 1;
        r.out_month = m;
        r.out_year = y;
      end
      OP_DIST: r.distance = (na >= nb) ? na - nb : nb - na;
      default: r.order = (na < nb) ? ORD_A : ((na > nb) ? ORD_B : ORD_EQ);
    endcase
    return r;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned sel;
    c.op = op_t'($urandom_range(0, 6));
    if ($urandom_range(0, 39) == 0) c.op = OP_BAD;
    c.ya = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9999) : $urandom_range(1, 2400);
    c.ma = $urandom_range(1, 12);
    c.da = $urandom_range(1, days_in(c.ma, c.ya));
    c.yb = ($urandom_range(0, 1) == 0) ? c.ya : $urandom_range(1, 9999);
    c.mb = $urandom_range(1, 12);
    c.db = $urandom_range(1, days_in(c.mb, c.yb));
    if ($urandom_range(0, 7) == 0) begin
      c.da = $urandom;
      c.ma = $urandom;
      c.ya = $urandom;
    end
    if ($urandom_range(0, 15) == 0) begin
      c.db = $urandom;
      c.mb = $urandom;
      c.yb = $urandom;
    end
    sel = $urandom_range(0, 3);
    case (sel)
      0: c.k = $urandom_range(0, 400);
      1: c.k = $urandom_range(0, 40000);
      2: c.k = $urandom_range(0, MAX_DAYNO);
      default: c.k = $urandom;
    endcase
    return c;
  endfunction

  task automatic send_cmd(cmd_t c);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    opcode <= c.op;
    day_a <= c.da;
    month_a <= c.ma;
    year_a <= c.ya;
    day_b <= c.db;
    month_b <= c.mb;
    year_b <= c.yb;
    offset_days <= c.k;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  function automatic row_t row(op_t op, int da, int ma, int ya, int db, int mb, int yb,
                               int k, bit fixed = 0, answer_t a = '0);
    row_t r;
    r.c = '{op, da, ma, ya, db, mb, yb, k};
    r.fixed = fixed;
    r.a = a;
    return r;
  endfunction

  function automatic answer_t status_only(status_t s);
    answer_t a;
    a = '0;
    a.status = s;
    return a;
  endfunction

  row_t directed[$];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        answer_t e;
        e = pending_answers.pop_front();
        n_checked++;
        if (is_leap !== e.is_leap) begin
          $error("is_leap exp %0d got %0d", e.is_leap, is_leap); errors++; end
        if (day_of_year !== e.day_of_year) begin
          $error("day_of_year exp %0d got %0d", e.day_of_year, day_of_year); errors++; end
        if (day_number !== e.day_number) begin
          $error("day_number exp %0d got %0d", e.day_number, day_number); errors++; end
        if (out_day !== e.out_day) begin
          $error("out_day exp %0d got %0d", e.out_day, out_day); errors++; end
        if (out_month !== e.out_month) begin
          $error("out_month exp %0d got %0d", e.out_month, out_month); errors++; end
        if (out_year !== e.out_year) begin
          $error("out_year exp %0d got %0d", e.out_year, out_year); errors++; end
        if (distance !== e.distance) begin
          $error("distance exp %0d got %0d", e.distance, distance); errors++; end
        if (order !== e.order) begin
          $error("order exp %0d got %0d", e.order, order); errors++; end
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++; end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_gregorian_day_number_unit NOT OK");
      $finish;
    end
  end

  initial begin
    answer_t a;
    cmd_t c;
    int unsigned tail;
    a = '0;
    a.day_number = 22'd0;
    directed.push_back(row(OP_DNUM, 1, 1, 1, 1, 1, 1, 0, 1, a));
    a = '0;
    a.day_number = MAX_DAYNO;
    directed.push_back(row(OP_DNUM, 31, 12, 9999, 1, 1, 1, 0, 1, a));
    a = '0;
    a.is_leap = 1'b1;
    directed.push_back(row(OP_LEAP, 29, 2, 2000, 1, 1, 1, 0, 1, a));
    directed.push_back(row(OP_LEAP, 1, 3, 1900, 1, 1, 1, 0));
    a = '0;
    a.day_of_year = 9'd366;
    directed.push_back(row(OP_ORD, 31, 12, 2024, 1, 1, 1, 0, 1, a));
    directed.push_back(row(OP_LEAP, 29, 2, 1900, 1, 1, 1, 0, 1, status_only(ST_BAD)));
    directed.push_back(row(OP_ORD, 31, 4, 2001, 1, 1, 1, 0, 1, status_only(ST_BAD)));
    directed.push_back(row(OP_DNUM, 0, 0, 0, 1, 1, 1, 0, 1, status_only(ST_BAD)));
    directed.push_back(row(OP_DNUM, 31, 15, 16383, 1, 1, 1, 0, 1, status_only(ST_BAD)));
    directed.push_back(row(OP_DNUM, 1, 1, 10000, 1, 1, 1, 0, 1, status_only(ST_BAD)));
    directed.push_back(row(OP_BAD, 1, 1, 2000, 1, 1, 1, 0, 1, status_only(ST_BAD)));
    directed.push_back(row(OP_MINUS, 1, 1, 1, 1, 1, 1, 1, 1, status_only(ST_RANGE)));
    directed.push_back(row(OP_PLUS, 31, 12, 9999, 1, 1, 1, 1, 1, status_only(ST_RANGE)));
    directed.push_back(row(OP_PLUS, 1, 1, 1, 1, 1, 1, 4194303, 1, status_only(ST_RANGE)));
    a = '0;
    a.out_day = 31; a.out_month = 12; a.out_year = 9999;
    directed.push_back(row(OP_PLUS, 1, 1, 1, 1, 1, 1, MAX_DAYNO, 1, a));
    a = '0;
    a.out_day = 1; a.out_month = 1; a.out_year = 1;
    directed.push_back(row(OP_MINUS, 31, 12, 9999, 1, 1, 1, MAX_DAYNO, 1, a));
    directed.push_back(row(OP_PLUS, 28, 2, 2000, 1, 1, 1, 1));
    directed.push_back(row(OP_MINUS, 1, 3, 2100, 1, 1, 1, 1));
    directed.push_back(row(OP_PLUS, 31, 12, 1999, 1, 1, 1, 146097));
    a = '0;
    a.distance = MAX_DAYNO;
    directed.push_back(row(OP_DIST, 1, 1, 1, 31, 12, 9999, 0, 1, a));
    directed.push_back(row(OP_DIST, 5, 6, 2020, 5, 6, 2020, 0));
    directed.push_back(row(OP_DIST, 1, 1, 2000, 30, 2, 2000, 0, 1, status_only(ST_BAD)));
    directed.push_back(row(OP_CMP, 1, 1, 2000, 2, 1, 2000, 0));
    directed.push_back(row(OP_CMP, 2, 1, 2000, 1, 1, 2000, 0));
    directed.push_back(row(OP_CMP, 9, 9, 999, 9, 9, 999, 0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      pending_answers.push_back(directed[i].fixed ? directed[i].a
                                                  : calendar_answer(directed[i].c));
      send_cmd(directed[i].c);
    end
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 14 : ((ph == 1) ? 68 : 0);
      repeat (520) begin
        c = random_cmd();
        pending_answers.push_back(calendar_answer(c));
        send_cmd(c);
      end
    end
    start <= 1'b0;
    tail = 0;
    while (pending_answers.size() != 0 && tail < 1000) begin
      @(posedge clk);
      tail++;
    end
    repeat (20) @(posedge clk);
    $display("sent %0d transactions over all opcodes, date extremes and error cases",
             n_sent);
    $display("checked %0d results, %0d mismatches", n_checked, errors);
    if (errors == 0 && pending_answers.size() == 0)
      $display("tb_gregorian_day_number_unit OK");
    else
      $display("tb_gregorian_day_number_unit NOT OK");
    $finish;
  end

endmodule

// ===== gregorian_day_number_unit.f =====
sv/gdn_pkg.sv
sv/gregorian_day_number_unit.sv
bench/tb_gregorian_day_number_unit.sv
